FILE: rtl/cds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types and constants of the CSS declaration splitter.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int unsigned PAREN_LEVEL_MAX_DEF = 255;

  // Result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_DECL  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // Characters of interest
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int unsigned SLOTS = 4;

  // One result beat
  typedef struct packed {
    logic       vld;
    logic [7:0] ch;
    logic [1:0] kind;
  } res_t;

  // All results caused by one input byte, in delivery order (slot 0 first)
  typedef res_t [SLOTS-1:0] bundle_t;

endpackage : cds_pkg
`default_nettype wire

FILE: rtl/css_declaration_splitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// css_declaration_splitter
// Splits CSS declaration text into name bytes, value bytes and end marks.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle. Each byte yields zero to four result beats
// (a released held slash or comment space, the byte itself, a declaration
// close and a text-finished mark at end of text); results leave at one beat
// per cycle, so output bandwidth sets the sustained rate when bytes expand.
// The classifier updates its state in the cycle a byte is taken and parks the
// byte's results in a two-entry queue; the sequencer behind it drains them,
// and run_last marks the final beat of each byte. Input stalls only when the
// queue is full.
// ----------------------------------------------------------------------------
module css_declaration_splitter
  import cds_pkg::*;
#(
  parameter int unsigned PAREN_LEVEL_MAX = PAREN_LEVEL_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char_out,
  output logic [1:0]      out_kind,
  output logic            out_run_last
);

  logic    take;
  logic    push;
  bundle_t push_data;
  logic    q_full;
  logic    q_pop;
  logic    q_nonempty;
  bundle_t q_head;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  cds_front #(
    .PAREN_LEVEL_MAX(PAREN_LEVEL_MAX)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .char_in     (in_char_in),
    .end_of_text (in_end_of_text),
    .push        (push),
    .push_data   (push_data)
  );

  cds_fifo #(
    .WIDTH($bits(bundle_t))
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  cds_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_nonempty   (q_nonempty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_out (out_char_out),
    .out_kind     (out_kind),
    .out_run_last (out_run_last)
  );

endmodule : css_declaration_splitter
`default_nettype wire

FILE: rtl/cds_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cds_fifo
// Two-entry queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module cds_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  nonempty,
  output logic [WIDTH-1:0]      head
);

  logic [WIDTH-1:0] ent_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign head     = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ pop;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_data;
    end
  end

endmodule : cds_fifo
`default_nettype wire

FILE: rtl/cds_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cds_front
// Byte classifier: tracks comment, quote and paren state and builds the
// bundle of results each accepted byte causes.
// ----------------------------------------------------------------------------
module cds_front
  import cds_pkg::*;
#(
  parameter int unsigned PAREN_LEVEL_MAX = PAREN_LEVEL_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] char_in,
  input  wire logic       end_of_text,
  output logic            push,
  output bundle_t         push_data
);

  localparam int unsigned PW = $clog2(PAREN_LEVEL_MAX + 1);
  localparam logic [PW-1:0] PMAX = PW'(PAREN_LEVEL_MAX);

  typedef struct packed {
    logic          in_value;
    logic          in_comment;
    logic          star_seen;
    logic          slash_held;
    logic          dq;
    logic          sq;
    logic [PW-1:0] paren;
    logic          prev_bs;
    logic          nonempty;
    logic          ends_space;
    logic          touched;
  } st_t;

  typedef struct packed {
    st_t  st;
    res_t res;
  } plain_t;

  localparam st_t ST_RESET = '0;

  st_t st_r, st_nxt;

  function automatic logic is_dropped(logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
  endfunction

  // Byte outside any comment and not opening one
  function automatic plain_t take_plain(st_t s_in, logic [7:0] c);
    plain_t p;
    logic   quoted;
    p        = '0;
    p.st     = s_in;
    quoted   = s_in.dq || s_in.sq;
    if (!s_in.in_value) begin
      if (c == CH_COLON) begin
        p.st.in_value   = 1'b1;
        p.st.touched    = 1'b0;
        p.st.nonempty   = 1'b0;
        p.st.ends_space = 1'b0;
      end else if (!is_dropped(c)) begin
        p.res           = '{vld: 1'b1, ch: c, kind: KIND_NAME};
        p.st.nonempty   = 1'b1;
        p.st.ends_space = (c == CH_SPACE);
      end
    end else if (c == CH_SEMI && !quoted && s_in.paren == '0) begin
      p.res = '{vld: 1'b1, ch: 8'h00, kind: KIND_DECL};
      p.st  = ST_RESET;
      p.st.in_comment = s_in.in_comment;
      p.st.star_seen  = s_in.star_seen;
      p.st.slash_held = s_in.slash_held;
    end else begin
      if (c == CH_DQUOTE && !s_in.prev_bs && !s_in.sq) begin
        p.st.dq = !s_in.dq;
      end else if (c == CH_SQUOTE && !s_in.prev_bs && !s_in.dq) begin
        p.st.sq = !s_in.sq;
      end else if (c == CH_LPAREN && !quoted) begin
        if (s_in.paren < PMAX) begin
          p.st.paren = s_in.paren + 1'b1;
        end
      end else if (c == CH_RPAREN && !quoted && s_in.paren != '0) begin
        p.st.paren = s_in.paren - 1'b1;
      end
      if (!is_dropped(c)) begin
        p.res           = '{vld: 1'b1, ch: c, kind: KIND_VALUE};
        p.st.nonempty   = 1'b1;
        p.st.ends_space = (c == CH_SPACE);
      end
      p.st.prev_bs = (c == CH_BSLASH);
    end
    return p;
  endfunction

  always_comb begin
    st_t    s;
    plain_t p;
    logic   dispatch;
    logic   may_comment;
    s           = st_r;
    p           = '0;
    push_data   = '0;
    dispatch    = 1'b1;
    may_comment = 1'b0;

    if (s.in_value) begin
      s.touched = 1'b1;
    end

    if (s.in_comment) begin
      if (s.star_seen && char_in == CH_SLASH) begin
        s.in_comment = 1'b0;
      end
      s.star_seen = (char_in == CH_STAR);
      dispatch    = 1'b0;
    end else if (s.slash_held) begin
      s.slash_held = 1'b0;
      if (char_in == CH_STAR) begin
        // Comment opens: stand in one space where the field needs it
        if (s.nonempty && !s.ends_space) begin
          push_data[0] = '{vld: 1'b1, ch: CH_SPACE,
                           kind: (s.in_value ? KIND_VALUE : KIND_NAME)};
          s.nonempty   = 1'b1;
          s.ends_space = 1'b1;
        end
        s.in_comment = 1'b1;
        s.star_seen  = 1'b0;
        dispatch     = 1'b0;
      end else begin
        p            = take_plain(s, CH_SLASH);
        s            = p.st;
        push_data[0] = p.res;
      end
    end

    if (dispatch) begin
      may_comment = !s.in_value || (!s.dq && !s.sq);
      if (char_in == CH_SLASH && !end_of_text && may_comment) begin
        s.slash_held = 1'b1;
      end else begin
        p            = take_plain(s, char_in);
        s            = p.st;
        push_data[1] = p.res;
      end
    end

    if (end_of_text) begin
      if (s.in_value && s.touched) begin
        push_data[2] = '{vld: 1'b1, ch: 8'h00, kind: KIND_DECL};
      end
      push_data[3] = '{vld: 1'b1, ch: 8'h00, kind: KIND_DONE};
      s            = ST_RESET;
    end

    st_nxt = s;
    push   = take && (push_data[0].vld || push_data[1].vld ||
                      push_data[2].vld || push_data[3].vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (take) begin
      st_r <= st_nxt;
    end
  end

endmodule : cds_front
`default_nettype wire

FILE: rtl/cds_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cds_back
// Result sequencer: unpacks one bundle at a time into single result beats.
// ----------------------------------------------------------------------------
module cds_back
  import cds_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_nonempty,
  input  wire bundle_t  q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [7:0]    out_char_out,
  output logic [1:0]    out_kind,
  output logic          out_run_last
);

  bundle_t           cur_r;
  logic [SLOTS-1:0]  pend_r, pend_nxt;
  logic [SLOTS-1:0]  sel;
  logic [SLOTS-1:0]  left;
  logic              found;

  // Pick the lowest pending slot
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pend_r[i] && !found) begin
        sel[i] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  always_comb begin
    out_char_out = '0;
    out_kind     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel[i]) begin
        out_char_out = cur_r[i].ch;
        out_kind     = cur_r[i].kind;
      end
    end
  end

  assign out_valid    = |pend_r;
  assign left         = pend_r & ~(sel & {SLOTS{out_ready}});
  assign out_run_last = ((pend_r & ~sel) == '0);
  assign q_pop        = q_nonempty && (left == '0);

  always_comb begin
    pend_nxt = left;
    if (q_pop) begin
      for (int i = 0; i < SLOTS; i++) begin
        pend_nxt[i] = q_head[i].vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

endmodule : cds_back
`default_nettype wire
